### rtl/icfm_pkg.sv
// Package for the input-capture frequency meter.
// Holds widths, register indexes and the controller/datapath command and status types.
`timescale 1ns / 1ps

package icfm_pkg;

  localparam int COUNTER_BITS  = 16;
  localparam int FRACTION_BITS = 8;

  localparam int OVF_W    = 16;
  localparam int CLK_W    = 27;
  localparam int PRESC_W  = 11;
  localparam int CAP_W    = 16;
  localparam int PERIOD_W = 32;
  localparam int FREQ_W   = CLK_W + FRACTION_BITS;
  localparam int DEN_W    = PRESC_W + PERIOD_W;
  localparam int CFG_W    = (CLK_W > PRESC_W) ? CLK_W : PRESC_W;
  localparam int IDX_W    = 2;

  // One quotient bit per divider step.
  localparam int DIV_STEPS = FREQ_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [IDX_W-1:0] REG_INPUT_CLOCK_HZ   = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_PRESCALE_DIVISOR = IDX_W'(1);

  localparam logic CMD_OVERFLOW = 1'b0;
  localparam logic CMD_CAPTURE  = 1'b1;

  localparam logic [CLK_W-1:0]   RESET_INPUT_CLOCK_HZ   = CLK_W'(16000000);
  localparam logic [PRESC_W-1:0] RESET_PRESCALE_DIVISOR = PRESC_W'(64);

  typedef struct packed {
    logic ovf_inc;    // count one timer overflow
    logic capture;    // compute the period and store the capture
    logic load_den;   // register prescaler times period, start the divider
    logic div_step;   // one restoring division step
    logic load_out;   // move the result into the output register
  } icfm_cmd_t;

  typedef struct packed {
    logic period_zero;
  } icfm_status_t;

endpackage

### rtl/icfm_datapath.sv
// Datapath of the input-capture frequency meter: configuration, capture state,
// period arithmetic, the radix-2 divider and the output register. Uses icfm_pkg.
`timescale 1ns / 1ps

module icfm_datapath
  import icfm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic [CAP_W-1:0]    capture_value,
  input  icfm_cmd_t           cmd_bus,
  output icfm_status_t        status,
  output logic [PERIOD_W-1:0] period_ticks,
  output logic [FREQ_W-1:0]   frequency_q8,
  output logic                zero_period
);

  logic [CLK_W-1:0]    input_clock_hz;
  logic [PRESC_W-1:0]  prescale_divisor;
  logic [OVF_W-1:0]    overflow_count;
  logic [OVF_W-1:0]    last_overflow_count;
  logic [CAP_W-1:0]    last_capture;
  logic [PERIOD_W-1:0] period_work;
  logic [DEN_W-1:0]    den;
  logic [DEN_W-1:0]    rem;
  logic [FREQ_W-1:0]   quot;

  logic [OVF_W-1:0]    ovf_delta;
  logic [PERIOD_W-1:0] period_next;
  logic [PRESC_W-1:0]  presc_eff;
  logic [DEN_W:0]      trial;
  logic [DEN_W:0]      diff;

  always_comb begin
    ovf_delta   = overflow_count - last_overflow_count;
    period_next = (PERIOD_W'(ovf_delta) << COUNTER_BITS) + PERIOD_W'(capture_value)
                  - PERIOD_W'(last_capture);
    presc_eff   = (prescale_divisor == '0) ? PRESC_W'(1) : prescale_divisor;
    trial       = {rem, quot[FREQ_W-1]};
    diff        = trial - {1'b0, den};
  end

  assign status.period_zero = (period_work == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      input_clock_hz      <= RESET_INPUT_CLOCK_HZ;
      prescale_divisor    <= RESET_PRESCALE_DIVISOR;
      overflow_count      <= '0;
      last_overflow_count <= '0;
      last_capture        <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_INPUT_CLOCK_HZ:   input_clock_hz   <= cfg_data[CLK_W-1:0];
          REG_PRESCALE_DIVISOR: prescale_divisor <= cfg_data[PRESC_W-1:0];
          default: ;
        endcase
      end
      if (cmd_bus.ovf_inc) begin
        overflow_count <= overflow_count + OVF_W'(1);
      end
      if (cmd_bus.capture) begin
        last_overflow_count <= overflow_count;
        last_capture        <= capture_value;
      end
    end
  end

  // Restoring division of the clock numerator by prescaler times period.
  // The remainder always stays below the divisor, so DEN_W bits hold it.
  always_ff @(posedge clk) begin
    if (cmd_bus.capture) begin
      period_work <= period_next;
    end
    if (cmd_bus.load_den) begin
      den  <= DEN_W'(presc_eff) * DEN_W'(period_work);
      rem  <= '0;
      quot <= {input_clock_hz, FRACTION_BITS'(0)};
    end else if (cmd_bus.div_step) begin
      if (!diff[DEN_W]) begin
        rem  <= diff[DEN_W-1:0];
        quot <= {quot[FREQ_W-2:0], 1'b1};
      end else begin
        rem  <= trial[DEN_W-1:0];
        quot <= {quot[FREQ_W-2:0], 1'b0};
      end
    end
    // The quotient never exceeds the numerator, so it always fits the output.
    if (cmd_bus.load_out) begin
      period_ticks <= period_work;
      zero_period  <= status.period_zero;
      frequency_q8 <= status.period_zero ? '0 : quot;
    end
  end

endmodule

### rtl/icfm_controller.sv
// Controller of the input-capture frequency meter: sequences capture, divide
// and output, and owns the handshakes. Uses icfm_pkg.
`timescale 1ns / 1ps

module icfm_controller
  import icfm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic         cmd,
  output logic         out_valid,
  input  logic         out_stall,
  input  icfm_status_t status,
  output icfm_cmd_t    cmd_bus
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              out_free;
  logic              in_xfer;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd_bus    = '0;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          if (cmd == CMD_CAPTURE) begin
            cmd_bus.capture = 1'b1;
            state_next      = S_MUL;
          end else begin
            cmd_bus.ovf_inc = 1'b1;
          end
        end
      end
      S_MUL: begin
        step_next = '0;
        if (status.period_zero) begin
          state_next = S_OUT;
        end else begin
          cmd_bus.load_den = 1'b1;
          state_next       = S_DIV;
        end
      end
      S_DIV: begin
        cmd_bus.div_step = 1'b1;
        step_next        = step + STEP_W'(1);
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd_bus.load_out = 1'b1;
          state_next       = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (cmd_bus.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/input_capture_frequency_meter.sv
// Input-capture frequency meter, top level: controller and datapath.
// An overflow event is taken in the idle state and gives no result. After a capture's
// transfer come a multiply state, 35 divider steps of one quotient bit each and an
// output-load state that raises out_valid; a zero period skips the divider steps. The
// next event is taken back in idle. A stalled result at the output delays the output load.
// Synchronous active-high reset clears the counts and capture, restores 16 MHz and 64.
`timescale 1ns / 1ps

module input_capture_frequency_meter
  import icfm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                cmd,
  input  logic [CAP_W-1:0]    capture_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [PERIOD_W-1:0] period_ticks,
  output logic [FREQ_W-1:0]   frequency_q8,
  output logic                zero_period
);

  icfm_cmd_t    cmd_bus;
  icfm_status_t status;

  icfm_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd_bus   (cmd_bus)
  );

  icfm_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .capture_value (capture_value),
    .cmd_bus       (cmd_bus),
    .status        (status),
    .period_ticks  (period_ticks),
    .frequency_q8  (frequency_q8),
    .zero_period   (zero_period)
  );

endmodule

### rtl/icfm_checker.sv
// Port-level checker for the input-capture frequency meter, bound to the top level.
// Uses icfm_pkg for widths and command codes.
`timescale 1ns / 1ps

module icfm_checker
  import icfm_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                cmd,
  input logic                out_valid,
  input logic                out_stall,
  input logic [PERIOD_W-1:0] period_ticks,
  input logic [FREQ_W-1:0]   frequency_q8,
  input logic                zero_period
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(period_ticks) && $stable(frequency_q8))
    else $error("stalled result changed");

  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (zero_period == (period_ticks == '0))
                  && (!zero_period || frequency_q8 == '0))
    else $error("zero-period flag inconsistent with result");

  a_busy_after_capture: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && cmd == CMD_CAPTURE |=> in_stall)
    else $error("new event taken while a capture is being measured");

endmodule

bind input_capture_frequency_meter icfm_checker u_icfm_checker (.*);

### bench/testbench.sv
// Testbench for the input-capture frequency meter: directed events, register extremes,
// long overflow runs and random traffic. Depends on icfm_pkg and the meter top level;
// every result is compared with a period and frequency model kept in this file.
`timescale 1ns / 1ps

module testbench;
  import icfm_pkg::*;

  localparam int DRAIN_CYCLES = 48;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int MAX_REPORTS  = 10;
  localparam int IDLE_PERCENT = 26;
  localparam logic [IDX_W-1:0] REG_SPARE_2 = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_SPARE_3 = IDX_W'(3);
  localparam logic [CLK_W-1:0] CLK_HZ_TOP  = {CLK_W{1'b1}};
  localparam logic [63:0]      FREQ_TOP    = (64'd1 << FREQ_W) - 64'd1;

  typedef struct packed {
    logic [PERIOD_W-1:0] ticks;
    logic [FREQ_W-1:0]   freq;
    logic                zero;
  } meas_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write = 1'b0;
  logic [IDX_W-1:0]    cfg_index = '0;
  logic [CFG_W-1:0]    cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                cmd = CMD_OVERFLOW;
  logic [CAP_W-1:0]    capture_value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [PERIOD_W-1:0] period_ticks;
  logic [FREQ_W-1:0]   frequency_q8;
  logic                zero_period;

  // Mirror of the meter's registers and counts.
  logic [CLK_W-1:0]   clock_hz;
  logic [PRESC_W-1:0] prescale;
  logic [OVF_W-1:0]   overflows;
  logic [OVF_W-1:0]   overflows_at_last;
  logic [CAP_W-1:0]   last_cap;

  meas_t expected_meas[$];
  meas_t oldest_meas;
  bit    steady = 1'b0;
  int    cycle_count = 0;
  int    mismatches = 0;
  int    results_seen = 0;
  int    captures_sent = 0;
  int    overflows_sent = 0;
  int    zero_periods = 0;
  int    settings_used = 0;

  input_capture_frequency_meter uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .capture_value(capture_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .period_ticks(period_ticks),
    .frequency_q8(frequency_q8),
    .zero_period(zero_period)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("run stopped at the cycle limit with %0d results outstanding",
               expected_meas.size());
      $display("status: fail");
      $finish;
    end
  end

  // Result checker: compares each accepted transfer with the oldest pending measurement.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (expected_meas.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("cycle %0d: result with no capture pending", cycle_count);
        mismatches <= mismatches + 1;
      end else begin
        oldest_meas = expected_meas.pop_front();
        if (period_ticks !== oldest_meas.ticks || frequency_q8 !== oldest_meas.freq ||
            zero_period !== oldest_meas.zero) begin
          if (mismatches < MAX_REPORTS)
            $display("cycle %0d: period %0d/%0d freq %0d/%0d zero %0b/%0b (expected/actual)",
                     cycle_count, oldest_meas.ticks, period_ticks, oldest_meas.freq,
                     frequency_q8, oldest_meas.zero, zero_period);
          mismatches <= mismatches + 1;
        end
      end
    end
    out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
  end

  function automatic logic [PERIOD_W-1:0] period_since_last(logic [CAP_W-1:0] cap);
    logic [OVF_W-1:0] wraps;
    wraps = overflows - overflows_at_last;
    return (PERIOD_W'(wraps) << COUNTER_BITS) + PERIOD_W'(cap) - PERIOD_W'(last_cap);
  endfunction

  function automatic logic [FREQ_W-1:0] frequency_of(logic [PERIOD_W-1:0] ticks);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] quot;
    num = 64'(clock_hz) << FRACTION_BITS;
    // A prescaler of zero divides by one.
    den = 64'((prescale == '0) ? PRESC_W'(1) : prescale) * 64'(ticks);
    if (den == 64'd0)
      return '0;
    quot = num / den;
    if (quot > FREQ_TOP)
      quot = FREQ_TOP;
    return quot[FREQ_W-1:0];
  endfunction

  task automatic apply_event(logic kind, logic [CAP_W-1:0] cap);
    meas_t m;
    if (kind == CMD_OVERFLOW) begin
      overflows = overflows + 1'b1;
      overflows_sent++;
    end else begin
      m.ticks = period_since_last(cap);
      m.zero = (m.ticks == '0);
      m.freq = m.zero ? '0 : frequency_of(m.ticks);
      last_cap = cap;
      overflows_at_last = overflows;
      expected_meas.push_back(m);
      captures_sent++;
      if (m.zero)
        zero_periods++;
    end
  endtask

  // Offers one event and returns at the edge where the transfer takes place.
  task automatic send_event(logic kind, logic [CAP_W-1:0] cap);
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= kind;
    capture_value <= cap;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    apply_event(kind, cap);
  endtask

  // Drains every pending result, then lets a trailing overflow or capture finish.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_meas.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_INPUT_CLOCK_HZ:   clock_hz = data[CLK_W-1:0];
      REG_PRESCALE_DIVISOR: prescale = data[PRESC_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(logic [CLK_W-1:0] hz, logic [PRESC_W-1:0] presc);
    settle();
    write_reg(REG_INPUT_CLOCK_HZ, CFG_W'(hz));
    // Junk above the prescaler field must be dropped by the register.
    write_reg(REG_PRESCALE_DIVISOR, (CFG_W'($urandom) << PRESC_W) | CFG_W'(presc));
    settings_used++;
  endtask

  task automatic test_directed();
    send_event(CMD_CAPTURE, 16'd1000);   // the first capture counts from reset
    send_event(CMD_CAPTURE, 16'd1000);   // same value, no overflow: zero period
    send_event(CMD_CAPTURE, 16'd999);    // lower value, no overflow: wraps modulo 2^32
    send_event(CMD_OVERFLOW, 16'hFFFF);
    send_event(CMD_CAPTURE, 16'd0);
    send_event(CMD_OVERFLOW, 16'h0000);
    send_event(CMD_OVERFLOW, 16'h5A5A);
    send_event(CMD_CAPTURE, 16'hFFFF);
    send_event(CMD_CAPTURE, 16'hFFFF);
    send_event(CMD_OVERFLOW, 16'hA5A5);
    send_event(CMD_CAPTURE, 16'hFFFF);   // exactly one timer wrap
    send_event(CMD_CAPTURE, 16'd0);
    send_event(CMD_CAPTURE, 16'd1);
  endtask

  task automatic test_register_extremes();
    set_config(CLK_HZ_TOP, PRESC_W'(0));
    send_event(CMD_CAPTURE, last_cap + 1'b1);   // highest frequency the fields allow
    settle();
    write_reg(REG_SPARE_2, CFG_W'($urandom));
    write_reg(REG_SPARE_3, '1);
    send_event(CMD_CAPTURE, last_cap + 1'b1);
    set_config(CLK_W'(1), PRESC_W'(2047));
    send_event(CMD_OVERFLOW, 16'h0);
    send_event(CMD_OVERFLOW, 16'hFFFF);
    send_event(CMD_CAPTURE, 16'h8000);
    set_config(CLK_W'(0), PRESC_W'(1024));
    send_event(CMD_CAPTURE, 16'h1234);
    set_config(CLK_W'(100000000), PRESC_W'(1));
    send_event(CMD_CAPTURE, last_cap + 1'b1);
    set_config(CLK_W'(1), PRESC_W'(1024));
    send_event(CMD_CAPTURE, last_cap + 1'b1);
  endtask

  // Long back-to-back runs of overflow events give periods of many timer wraps.
  task automatic test_overflow_runs();
    set_config(RESET_INPUT_CLOCK_HZ, RESET_PRESCALE_DIVISOR);
    steady = 1'b1;
    send_event(CMD_CAPTURE, 16'd100);
    repeat (150) send_event(CMD_OVERFLOW, CAP_W'($urandom));
    send_event(CMD_CAPTURE, 16'd100);
    repeat (120) send_event(CMD_OVERFLOW, CAP_W'($urandom));
    send_event(CMD_CAPTURE, 16'd99);
    steady = 1'b0;
  endtask

  task automatic test_random_traffic(int per_phase);
    int phase;
    int sent;
    logic [CAP_W-1:0] cap;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_config(RESET_INPUT_CLOCK_HZ, RESET_PRESCALE_DIVISOR);
        1: set_config(CLK_W'(100000000), PRESC_W'(1));
        2: set_config(CLK_W'($urandom_range(1, 100000000)), PRESC_W'($urandom_range(1, 1024)));
        3: set_config(CLK_W'(1), PRESC_W'(1024));
        4: set_config(CLK_W'($urandom), PRESC_W'($urandom));
        default: set_config(CLK_W'($urandom_range(1000000, 50000000)),
                            PRESC_W'($urandom_range(1, 8)));
      endcase
      // One phase runs with no idling on either side.
      steady = (phase == 2);
      sent = 0;
      while (sent < per_phase) begin
        if ($urandom_range(0, 99) < 30) begin
          repeat ($urandom_range(1, 3)) begin
            send_event(CMD_OVERFLOW, CAP_W'($urandom));
            sent++;
          end
        end else begin
          case ($urandom_range(0, 3))
            0: cap = CAP_W'($urandom);
            1: cap = last_cap + CAP_W'($urandom_range(0, 64));
            2: cap = last_cap;
            default: cap = $urandom_range(0, 1) ? CAP_W'($urandom_range(0, 15))
                                                : ~CAP_W'($urandom_range(0, 15));
          endcase
          send_event(CMD_CAPTURE, cap);
          sent++;
        end
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    clock_hz = RESET_INPUT_CLOCK_HZ;
    prescale = RESET_PRESCALE_DIVISOR;
    overflows = '0;
    overflows_at_last = '0;
    last_cap = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_register_extremes();
    test_overflow_runs();
    test_random_traffic(200);
    settle();
    $display("sent %0d captures (%0d of zero period) and %0d overflow events",
             captures_sent, zero_periods, overflows_sent);
    $display("over %0d register settings; %0d results checked, %0d mismatches",
             settings_used, results_seen, mismatches);
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

### files.f
rtl/icfm_pkg.sv
rtl/icfm_datapath.sv
rtl/icfm_controller.sv
rtl/input_capture_frequency_meter.sv
rtl/icfm_checker.sv
bench/testbench.sv
